### rtl/jbcd_pkg.sv
// Shared types and constants for the JPEG block coefficient decoder.
package jbcd_pkg;

   localparam int unsigned BLOCK_COEFFS = 64;
   localparam int unsigned POS_W        = $clog2(BLOCK_COEFFS);
   localparam int unsigned SYM_W        = 8;
   localparam int unsigned AMP_W        = 15;
   localparam int unsigned COEF_W       = 16;
   localparam int unsigned NIB_W        = 4;
   localparam int unsigned CSR_INDEX_W  = 1;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SPECTRAL_START = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPECTRAL_END   = 1'b1;

   localparam logic [SYM_W-1:0] SYM_EOB = 8'h00;

   // shared adder operations
   typedef enum logic [1:0] {
      ALU_HOLD,
      ALU_EXT,
      ALU_ADD
   } alu_op_type;

endpackage

### rtl/jpeg_block_coefficient_decoder.sv
// Top level: symbol sequencer expanding run/size symbols into block coefficients.
// Order: after accept, a DC item passes the extend, add and emit states before rsp_valid rises;
// an AC item passes extend and emit; later coefficients follow one per cycle unless stalled.
// Throughput: req_stall holds the input until the item's last coefficient is emitted;
// the emit sequencer delivers one coefficient per cycle at most.
// Reset (synchronous): spectral_start 0, spectral_end 63, no block open, no output.
module jpeg_block_coefficient_decoder (
   input  logic                                     clock,
   input  logic                                     reset,
   // request channel
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [jbcd_pkg::SYM_W-1:0]               req_symbol,
   input  logic [jbcd_pkg::AMP_W-1:0]               req_amplitude_bits,
   input  logic signed [jbcd_pkg::COEF_W-1:0]       req_dc_predictor,
   // result channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic signed [jbcd_pkg::COEF_W-1:0]       rsp_coefficient,
   output logic [jbcd_pkg::POS_W-1:0]               rsp_coefficient_index,
   output logic                                     rsp_last,
   output logic                                     rsp_run_overflow,
   // register write port
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [jbcd_pkg::CSR_INDEX_W-1:0]         csr_index,
   input  logic [jbcd_pkg::POS_W-1:0]               csr_data
);

   localparam int unsigned PW = jbcd_pkg::POS_W;
   localparam int unsigned NW = jbcd_pkg::NIB_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXT,
      ST_ADD,
      ST_EMIT
   } state_type;

   state_type state_ff;

   // configuration
   logic [PW-1:0] start_ff;
   logic [PW-1:0] end_ff;

   // block state
   logic [PW-1:0] np_ff;
   logic          open_ff;

   // current request
   logic [NW-1:0]                      size_ff;
   logic [jbcd_pkg::AMP_W-1:0]         amp_ff;
   logic signed [jbcd_pkg::COEF_W-1:0] pred_ff;
   logic                               dc_ff;     // DC item: add predictor after extend
   logic                               fill_ff;   // zero fill to the end (EOB or clipped run)
   logic                               ovf_ff;
   logic [PW-1:0]                      pos_ff;
   logic [PW-1:0]                      end_eff_ff;
   logic [NW-1:0]                      run_ff;

   // output register
   logic                               rsp_valid_ff;
   logic signed [jbcd_pkg::COEF_W-1:0] rsp_coef_ff;
   logic [PW-1:0]                      rsp_index_ff;
   logic                               rsp_last_ff;
   logic                               rsp_ovf_ff;

   // accept-time decode
   logic [PW-1:0] end_eff;
   logic          open_ok;
   logic [PW-1:0] pos;
   logic [NW-1:0] run;
   logic [PW:0]   run_reach;
   logic          is_dc;
   logic          is_eob;
   logic          clip;
   logic          accept;
   logic          emit;
   logic          at_end;

   jbcd_pkg::alu_op_type               alu_op;
   logic signed [jbcd_pkg::COEF_W-1:0] alu_result;

   assign end_eff   = (end_ff < start_ff) ? start_ff : end_ff;
   // a block left open outside a changed range is abandoned
   assign open_ok   = open_ff && (np_ff >= start_ff) && (np_ff <= end_eff);
   assign pos       = open_ok ? np_ff : start_ff;
   assign run       = req_symbol[jbcd_pkg::SYM_W-1:NW];
   assign run_reach = {1'b0, pos} + {{(PW+1-NW){1'b0}}, run};

   // position 0 is always the DC term; EOB is checked before the run clip
   assign is_dc  = (pos == '0);
   assign is_eob = !is_dc && (req_symbol == jbcd_pkg::SYM_EOB);
   assign clip   = !is_dc && !is_eob && (run_reach > {1'b0, end_eff});

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // one coefficient per cycle whenever the output register frees up
   assign emit   = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign at_end = (pos_ff == end_eff_ff);

   always_comb begin
      case (state_ff)
         ST_EXT:  alu_op = jbcd_pkg::ALU_EXT;
         ST_ADD:  alu_op = jbcd_pkg::ALU_ADD;
         default: alu_op = jbcd_pkg::ALU_HOLD;
      endcase
   end

   jbcd_alu u_alu (
      .clock     (clock),
      .op        (alu_op),
      .size      (size_ff),
      .amp       (amp_ff),
      .pred      (pred_ff),
      .result_ff (alu_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= '0;
         end_ff       <= PW'(jbcd_pkg::BLOCK_COEFFS - 1);
         np_ff        <= '0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               jbcd_pkg::CSR_SPECTRAL_START: start_ff <= csr_data;
               jbcd_pkg::CSR_SPECTRAL_END:   end_ff   <= csr_data;
               default: ;
            endcase
         end

         // taken result leaves unless a new one replaces it this cycle
         if (rsp_valid_ff && !rsp_stall && !emit)
            rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  size_ff    <= req_symbol[NW-1:0];
                  amp_ff     <= req_amplitude_bits;
                  pred_ff    <= req_dc_predictor;
                  pos_ff     <= pos;
                  end_eff_ff <= end_eff;
                  open_ff    <= 1'b1;
                  dc_ff      <= is_dc;
                  fill_ff    <= is_eob || clip;
                  ovf_ff     <= clip;
                  run_ff     <= is_dc ? '0 : run;
                  state_ff   <= ST_EXT;
               end
            end
            ST_EXT: begin
               state_ff <= dc_ff ? ST_ADD : ST_EMIT;
            end
            ST_ADD: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (emit) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_index_ff <= pos_ff;
                  rsp_ovf_ff   <= ovf_ff;
                  if (fill_ff || run_ff != '0) begin
                     // zero of a run or of an end-of-block fill
                     rsp_coef_ff <= '0;
                     rsp_last_ff <= fill_ff && at_end;
                     if (fill_ff && at_end) begin
                        open_ff  <= 1'b0;
                        np_ff    <= '0;
                        state_ff <= ST_IDLE;
                     end else begin
                        pos_ff <= pos_ff + PW'(1);
                        if (!fill_ff)
                           run_ff <= run_ff - NW'(1);
                     end
                  end else begin
                     // the amplitude itself closes the item
                     rsp_coef_ff <= alu_result;
                     rsp_last_ff <= at_end;
                     if (at_end) begin
                        open_ff <= 1'b0;
                        np_ff   <= '0;
                     end else begin
                        np_ff <= pos_ff + PW'(1);
                     end
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_coefficient       = rsp_coef_ff;
   assign rsp_coefficient_index = rsp_index_ff;
   assign rsp_last              = rsp_last_ff;
   assign rsp_run_overflow      = rsp_ovf_ff;

endmodule

### rtl/jbcd_alu.sv
// Shared 16-bit adder: amplitude sign extension and DC predictor add.
module jbcd_alu (
   input  logic                                  clock,
   input  jbcd_pkg::alu_op_type                  op,
   input  logic [jbcd_pkg::NIB_W-1:0]            size,
   input  logic [jbcd_pkg::AMP_W-1:0]            amp,
   input  logic signed [jbcd_pkg::COEF_W-1:0]    pred,
   output logic signed [jbcd_pkg::COEF_W-1:0]    result_ff
);

   logic [jbcd_pkg::COEF_W-1:0] mask;
   logic [jbcd_pkg::COEF_W-1:0] bits_m;
   logic                        neg;
   logic [jbcd_pkg::COEF_W-1:0] opa;
   logic [jbcd_pkg::COEF_W-1:0] opb;
   logic signed [jbcd_pkg::COEF_W-1:0] result_in;

   // low size bits; a clear top bit marks a negative amplitude
   assign mask   = (jbcd_pkg::COEF_W'(1) << size) - jbcd_pkg::COEF_W'(1);
   assign bits_m = {1'b0, amp} & mask;
   assign neg    = (size != '0) && !bits_m[size - jbcd_pkg::NIB_W'(1)];

   always_comb begin
      opa = bits_m;
      opb = neg ? ~mask + jbcd_pkg::COEF_W'(1) : '0;   // 1 - 2^size
      if (op == jbcd_pkg::ALU_ADD) begin
         opa = result_ff;
         opb = pred;
      end
   end

   always_comb begin
      result_in = result_ff;
      case (op)
         jbcd_pkg::ALU_EXT,
         jbcd_pkg::ALU_ADD: result_in = opa + opb;
         default:           result_in = result_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

endmodule
